FILE: hdl/julia_escape_time_pixel_macros.svh
// ----------------------------------------------------------------------------
// Julia escape-time pixel assertion macros
// Shared concurrent assertion wrappers, empty when built for synthesis.
// ----------------------------------------------------------------------------
`ifndef JULIA_ESCAPE_TIME_PIXEL_MACROS_SVH
`define JULIA_ESCAPE_TIME_PIXEL_MACROS_SVH
`ifndef SYNTHESIS
`define JET_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define JET_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`else
`define JET_ASSERT(lbl, prop, msg)
`define JET_ASSERT_IMPLIES(lbl, ante, cons, msg)
`endif
`endif

FILE: hdl/jet_pkg.sv
// ----------------------------------------------------------------------------
// Julia escape-time pixel package
// Widths, fixed-point constants, register codes and the beat passed between
// iteration cells.
// ----------------------------------------------------------------------------
package jet_pkg;

  localparam int JetTileSize = 64;
  localparam int JetMaxIter  = 64;

  localparam int JetQW    = 21;
  localparam int JetFrac  = 16;
  localparam int JetCW    = 18;
  localparam int JetCntW  = 8;
  localparam int JetIdxW  = 6;
  localparam int JetOutW  = 7;

  localparam longint JetHalfQ = 98304;
  localparam longint JetFourQ = 262144;
  localparam longint JetQMax  = 1048575;
  localparam longint JetQMin  = -1048576;

  localparam logic signed [JetCW-1:0] JetCRealRst = -18'sd13107;
  localparam logic signed [JetCW-1:0] JetCImagRst = 18'sd26214;

  typedef logic signed [JetQW-1:0] coord_t;

  typedef enum logic [0:0] {
    CfgCReal = 1'b0,
    CfgCImag = 1'b1
  } jet_cfg_e;

  typedef struct packed {
    logic               valid;
    logic               done;
    logic [JetCntW-1:0] count;
    coord_t             x;
    coord_t             y;
  } jet_beat_t;

endpackage

FILE: hdl/jet_start_lut.sv
// ----------------------------------------------------------------------------
// Julia escape-time start coordinate table
// Maps a pixel index inside the tile to its saturated Q4.16 start value.
// ----------------------------------------------------------------------------
module jet_start_lut
  import jet_pkg::*;
#(
  parameter int TileSize = JetTileSize
) (
  input  logic [JetIdxW-1:0] idx_i,
  output coord_t             coord_o
);

  localparam int Entries = 1 << JetIdxW;

  coord_t lut [Entries];

  for (genvar g = 0; g < Entries; g++) begin : g_lut
    localparam longint Num = longint'(g) * 3 * (longint'(1) << JetFrac);
    localparam longint Raw = Num / TileSize - JetHalfQ;
    localparam longint Sat = (Raw > JetQMax) ? JetQMax : ((Raw < JetQMin) ? JetQMin : Raw);
    assign lut[g] = coord_t'(Sat);
  end

  assign coord_o = lut[idx_i];

endmodule

FILE: hdl/jet_cell.sv
// ----------------------------------------------------------------------------
// Julia escape-time iteration cell
// Tests a beat that is not yet done for escape and, if still bounded, applies z = z^2 + c once.
// ----------------------------------------------------------------------------
module jet_cell
  import jet_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic signed [JetCW-1:0] c_real_i,
  input  logic signed [JetCW-1:0] c_imag_i,
  input  jet_beat_t               beat_i,
  output jet_beat_t               beat_o
);
`include "julia_escape_time_pixel_macros.svh"

  localparam int PW = 2 * JetQW;
  localparam int SW = PW - JetFrac;
  localparam int MW = SW + 1;

  logic signed [PW-1:0] xx, yy, xy;
  logic signed [SW-1:0] x2, y2;
  logic signed [MW-1:0] mag, nx_w, ny_w;
  logic                 escape;
  logic [JetCntW-1:0]   cnt_inc;
  logic                 done_in, step_in;
  jet_beat_t            beat_d, beat_q;

  always_comb begin
    xx      = beat_i.x * beat_i.x;
    yy      = beat_i.y * beat_i.y;
    xy      = beat_i.x * beat_i.y;
    x2      = xx[PW-1:JetFrac];
    y2      = yy[PW-1:JetFrac];
    mag     = MW'(x2) + MW'(y2);
    escape  = mag > MW'(JetFourQ);
    nx_w    = MW'(x2) - MW'(y2) + MW'(c_real_i);
    ny_w    = xy[PW-1:JetFrac-1] + MW'(c_imag_i);
    cnt_inc = beat_i.count + 1'b1;

    beat_d = beat_i;
    if (!beat_i.done) begin
      if (escape) begin
        beat_d.done = 1'b1;
      end else begin
        beat_d.count = cnt_inc;
        beat_d.x     = nx_w[JetQW-1:0];
        beat_d.y     = ny_w[JetQW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_q <= '0;
    end else if (en_i) begin
      beat_q <= beat_d;
    end
  end

  assign beat_o = beat_q;

  assign done_in = en_i && beat_i.valid && beat_i.done;
  assign step_in = en_i && beat_i.valid && !beat_i.done && !escape;

  `JET_ASSERT(a_done_holds, done_in |=> beat_q == $past(beat_i), "Finished beat altered")
  `JET_ASSERT(a_step_counts, step_in |=> beat_q.count == $past(cnt_inc), "Step not counted")
  `JET_ASSERT(a_frozen, !en_i |=> $stable(beat_q), "Cell moved while frozen")

endmodule

FILE: hdl/julia_escape_time_pixel.sv
// ----------------------------------------------------------------------------
// Julia escape-time pixel evaluator
// Maps a tile pixel to a start point and counts Julia iterations to escape.
// ----------------------------------------------------------------------------
// The block takes one pixel beat per cycle while not stalled and returns
// its iteration count in order. An entry register holds the start point,
// and a chain of MaxIter identical cells follows, each cell running one
// complex square-and-add step, so the sustained rate is one pixel per
// cycle while no result waits under stall. The whole chain freezes while
// a result waits under stall. Configuration writes should be made while
// the chain is empty.
module julia_escape_time_pixel
  import jet_pkg::*;
#(
  parameter int TileSize = JetTileSize,
  parameter int MaxIter  = JetMaxIter
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [0:0]         cfg_idx_i,
  input  logic [JetCW-1:0]   cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [JetIdxW-1:0] pixel_col_i,
  input  logic [JetIdxW-1:0] pixel_row_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [JetOutW-1:0] iteration_count_o
);
`include "julia_escape_time_pixel_macros.svh"

  localparam logic [JetCntW-1:0] OutMax = JetCntW'((1 << JetOutW) - 1);

  logic signed [JetCW-1:0] c_real_q, c_imag_q;
  logic                    en;
  coord_t                  x_start, y_start;
  jet_beat_t               chain [MaxIter+1];
  jet_beat_t               last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_real_q <= JetCRealRst;
      c_imag_q <= JetCImagRst;
    end else if (cfg_we_i) begin
      case (jet_cfg_e'(cfg_idx_i))
        CfgCReal: c_real_q <= cfg_wdata_i;
        CfgCImag: c_imag_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  jet_start_lut #(.TileSize(TileSize)) u_col_lut (
    .idx_i   (pixel_col_i),
    .coord_o (x_start)
  );

  jet_start_lut #(.TileSize(TileSize)) u_row_lut (
    .idx_i   (pixel_row_i),
    .coord_o (y_start)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain[0] <= '0;
    end else if (en) begin
      chain[0].valid <= in_valid_i;
      chain[0].done  <= 1'b0;
      chain[0].count <= '0;
      chain[0].x     <= x_start;
      chain[0].y     <= y_start;
    end
  end

  for (genvar g = 0; g < MaxIter; g++) begin : g_cell
    jet_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (en),
      .c_real_i (c_real_q),
      .c_imag_i (c_imag_q),
      .beat_i   (chain[g]),
      .beat_o   (chain[g+1])
    );
  end

  assign last              = chain[MaxIter];
  assign out_valid_o       = last.valid;
  assign iteration_count_o = (last.count > OutMax) ? OutMax[JetOutW-1:0]
                                                   : last.count[JetOutW-1:0];

  `JET_ASSERT_IMPLIES(a_stall_freeze, out_valid_o && out_stall_i, in_stall_o, "Input open")
  `JET_ASSERT_IMPLIES(a_count_bound, out_valid_o, int'(last.count) <= MaxIter, "Count too big")
  `JET_ASSERT(a_entry_load, (in_valid_i && !in_stall_o) |=> chain[0].valid, "Accepted beat lost")

endmodule

FILE: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// Julia escape-time pixel testbench
// Streams tile pixels through the evaluator under random burst gaps and
// output stalls, predicts each iteration count in fixed point, and checks
// the results in order across several Julia constants.
// ----------------------------------------------------------------------------
module tb_top;
  import jet_pkg::*;

  localparam int StallNone  = 0;
  localparam int StallLight = 1;
  localparam int StallHeavy = 2;
  localparam int HoldCycles = 300;

  typedef struct packed {
    logic [JetIdxW-1:0] col;
    logic [JetIdxW-1:0] row;
  } pixel_t;

  logic               clk_i             = 1'b0;
  logic               rst_ni            = 1'b0;
  logic               cfg_we_i          = 1'b0;
  logic [0:0]         cfg_idx_i         = CfgCReal;
  logic [JetCW-1:0]   cfg_wdata_i       = '0;
  logic               in_valid_i        = 1'b0;
  logic               in_stall_o;
  logic [JetIdxW-1:0] pixel_col_i       = '0;
  logic [JetIdxW-1:0] pixel_row_i       = '0;
  logic               out_valid_o;
  logic               out_stall_i       = 1'b0;
  logic [JetOutW-1:0] iteration_count_o;

  pixel_t                  pix_q[$];
  logic [JetOutW-1:0]      count_q[$];
  logic signed [JetCW-1:0] c_re_sh = JetCRealRst;
  logic signed [JetCW-1:0] c_im_sh = JetCImagRst;

  int err_n       = 0;
  int res_n       = 0;
  int trapped_n   = 0;
  int in_stall_n  = 0;
  int setting_n   = 1;
  int hold_asks   = 0;
  int hold_done   = 0;
  int hold_left   = 0;
  int burst_left  = 0;
  int gap_left    = 0;
  int stall_mode  = StallNone;
  int mode_left   = 0;
  pixel_t             next_pix;
  logic [JetOutW-1:0] want;

  logic [11:0] a_list[20] = '{
    {6'd0, 6'd0},   {6'd63, 6'd63}, {6'd0, 6'd63},  {6'd63, 6'd0},
    {6'd32, 6'd32}, {6'd32, 6'd0},  {6'd0, 6'd32},  {6'd63, 6'd32},
    {6'd32, 6'd63}, {6'd21, 6'd42}, {6'd42, 6'd21}, {6'd31, 6'd31},
    {6'd33, 6'd31}, {6'd1, 6'd1},   {6'd62, 6'd62}, {6'd16, 6'd48},
    {6'd48, 6'd16}, {6'd24, 6'd40}, {6'd40, 6'd24}, {6'd32, 6'd31}
  };

  julia_escape_time_pixel u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .pixel_col_i      (pixel_col_i),
    .pixel_row_i      (pixel_row_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .iteration_count_o(iteration_count_o)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  function automatic logic [JetOutW-1:0] escape_count(
    input logic [JetIdxW-1:0]      col,
    input logic [JetIdxW-1:0]      row,
    input logic signed [JetCW-1:0] cre,
    input logic signed [JetCW-1:0] cim
  );
    longint zx;
    longint zy;
    longint sx;
    longint sy;
    longint nx;
    int     n;
    zx = (longint'(col) * 3 * (longint'(1) << JetFrac)) / JetTileSize - JetHalfQ;
    zy = (longint'(row) * 3 * (longint'(1) << JetFrac)) / JetTileSize - JetHalfQ;
    if (zx > JetQMax) zx = JetQMax;
    if (zx < JetQMin) zx = JetQMin;
    if (zy > JetQMax) zy = JetQMax;
    if (zy < JetQMin) zy = JetQMin;
    for (n = 0; n < JetMaxIter; n++) begin
      sx = (zx * zx) >>> JetFrac;
      sy = (zy * zy) >>> JetFrac;
      if (sx + sy > JetFourQ) break;
      nx = sx - sy + longint'(cre);
      zy = ((zx * zy) >>> (JetFrac - 1)) + longint'(cim);
      zx = nx;
    end
    if (n > 127) n = 127;
    return JetOutW'(n);
  endfunction

  task automatic add_pixel(input pixel_t p);
    pix_q.insert(pix_q.size(), p);
  endtask

  task automatic add_count(input logic [JetOutW-1:0] c);
    count_q.insert(count_q.size(), c);
  endtask

  // Sender: bursts of beats separated by random gaps; a stalled beat is held.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        add_count(escape_count(pixel_col_i, pixel_row_i, c_re_sh, c_im_sh));
      end
      if (in_valid_i && in_stall_o) begin
        in_stall_n++;
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (pix_q.size() > 0) begin
        next_pix = pix_q.pop_front();
        pixel_col_i <= next_pix.col;
        pixel_row_i <= next_pix.row;
        in_valid_i  <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: checks each result beat and stalls on its own pattern.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        res_n++;
        if (iteration_count_o == JetOutW'(JetMaxIter)) trapped_n++;
        if (count_q.size() == 0) begin
          err_n++;
          $display("%0t: unexpected result beat, expected none, got %0d",
                   $time, iteration_count_o);
        end else begin
          want = count_q.pop_front();
          if (iteration_count_o !== want) begin
            err_n++;
            $display("%0t: iteration_count mismatch, expected %0d, got %0d",
                     $time, want, iteration_count_o);
          end
        end
      end
      if (hold_asks != hold_done) begin
        hold_done++;
        hold_left = HoldCycles;
      end
      if (mode_left == 0) begin
        stall_mode = $urandom_range(StallNone, StallHeavy);
        mode_left  = $urandom_range(20, 80);
      end else begin
        mode_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        case (stall_mode)
          StallNone:  out_stall_i <= 1'b0;
          StallLight: out_stall_i <= ($urandom_range(0, 3) == 0);
          default:    out_stall_i <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  task automatic load_constant(input jet_cfg_e idx, input logic signed [JetCW-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgCReal) c_re_sh = val;
    else c_im_sh = val;
  endtask

  task automatic drain();
    while (pix_q.size() > 0 || in_valid_i || count_q.size() > 0) @(negedge clk_i);
    repeat (JetMaxIter + 8) @(negedge clk_i);
  endtask

  task automatic push_random(input int n);
    pixel_t p;
    for (int i = 0; i < n; i++) begin
      p.col = $urandom_range(0, 63);
      p.row = $urandom_range(0, 63);
      add_pixel(p);
    end
  endtask

  task automatic run_setting(input int cre, input int cim, input int n, input bit hold);
    pixel_t p;
    load_constant(CfgCReal, JetCW'(cre));
    load_constant(CfgCImag, JetCW'(cim));
    setting_n++;
    p = '{col: 6'd32, row: 6'd32};
    add_pixel(p);
    p = '{col: 6'd0, row: 6'd63};
    add_pixel(p);
    push_random(n);
    if (hold) hold_asks++;
    drain();
  endtask

  initial begin
    pixel_t p;
    int     a;
    int     b;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Corners, edges, center, near-center and other fixed points, then random ones, with the reset constant.
    foreach (a_list[i]) begin
      p.col = a_list[i][11:6];
      p.row = a_list[i][5:0];
      add_pixel(p);
    end
    push_random(45);
    drain();

    run_setting(-98304, -98304, 40, 1'b0);
    run_setting(98304, 98304, 70, 1'b1);
    run_setting(0, 0, 40, 1'b0);
    run_setting(-52429, 10224, 45, 1'b0);
    a = $urandom_range(0, 196608) - 98304;
    b = $urandom_range(0, 196608) - 98304;
    run_setting(a, b, 70, 1'b1);
    a = $urandom_range(0, 196608) - 98304;
    b = $urandom_range(0, 196608) - 98304;
    run_setting(a, b, 35, 1'b0);
    run_setting(-98304, 98304, 25, 1'b0);

    $display("Checked %0d iteration counts over %0d Julia constants; %0d points never escaped,",
             res_n, setting_n, trapped_n);
    $display("the input was held off on %0d cycles.", in_stall_n);
    if (err_n == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Run timed out with %0d results still expected.", count_q.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

FILE: julia_escape_time_pixel.f
+incdir+hdl
hdl/jet_pkg.sv
hdl/jet_start_lut.sv
hdl/jet_cell.sv
hdl/julia_escape_time_pixel.sv
tb/sv/tb_top.sv
